>>> rtl/stable_priority_queue_core_assert.svh
// Assertion macros used by the stable priority queue top level.
`ifndef STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq assertion failed");
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq assertion failed");
`else
`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/spq_pkg.sv
// Types and constants of the stable priority queue.
package spq_pkg;

  localparam int ID_W      = 16;
  localparam int PRIO_W    = 16;
  localparam int SLOT_PR_W = 15;
  localparam int STATUS_W  = 3;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQUEUED = 3'd0,
    ST_INVALID  = 3'd1,
    ST_FULL     = 3'd2,
    ST_DEQUEUED = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

>>> rtl/spq_if.sv
// Request and result channel interfaces of the stable priority queue.
interface spq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [spq_pkg::ID_W-1:0]      proc_id;
  logic signed [spq_pkg::PRIO_W-1:0] prio;
  logic                          name_empty;

  modport source (output valid, func, proc_id, prio, name_empty, input ready);
  modport sink (input valid, func, proc_id, prio, name_empty, output ready);
endinterface

interface spq_out_if;
  logic                             valid;
  logic                             ready;
  logic [spq_pkg::STATUS_W-1:0]     status;
  logic [spq_pkg::ID_W-1:0]         out_id;
  logic [spq_pkg::SLOT_PR_W-1:0]    out_prio;

  modport source (output valid, status, out_id, out_prio, input ready);
  modport sink (input valid, status, out_id, out_prio, output ready);
endinterface

>>> rtl/spq_ctrl.sv
// Controller of the stable priority queue: request sequencing and result valid.
module spq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output spq_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // The update waits until the result register can take the new result.
        if (slot_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/spq_dp.sv
// Datapath of the stable priority queue: sorted compare-and-shift cells and result register.
module spq_dp #(
  parameter int QUEUE_DEPTH = 16,
  localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spq_pkg::cmd_t                     cmd,
  input  logic                              in_func,
  input  logic [spq_pkg::ID_W-1:0]          in_proc_id,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_prio,
  input  logic                              in_name_empty,
  output logic [spq_pkg::STATUS_W-1:0]      res_status,
  output logic [spq_pkg::ID_W-1:0]          res_id,
  output logic [spq_pkg::SLOT_PR_W-1:0]     res_prio,
  output logic [CntW-1:0]                   fill
);

  // Latched request.
  logic                              func_r;
  logic [spq_pkg::ID_W-1:0]          id_r;
  logic signed [spq_pkg::PRIO_W-1:0] prio_r;
  logic                              nempty_r;

  // Queue cells, head at index 0.
  logic [spq_pkg::ID_W-1:0]      cell_id_r   [QUEUE_DEPTH];
  logic [spq_pkg::SLOT_PR_W-1:0] cell_prio_r [QUEUE_DEPTH];
  logic [CntW-1:0]               fill_r, fill_nxt;

  spq_pkg::status_t              status_r, status_nxt;
  logic [spq_pkg::ID_W-1:0]      res_id_r, res_id_nxt;
  logic [spq_pkg::SLOT_PR_W-1:0] res_prio_r, res_prio_nxt;

  logic [spq_pkg::SLOT_PR_W-1:0] new_prio;
  logic bad, full, empty, enq_ok, deq_ok;
  logic [QUEUE_DEPTH-1:0] lower;

  assign new_prio = prio_r[spq_pkg::SLOT_PR_W-1:0];
  assign bad      = nempty_r || prio_r[spq_pkg::PRIO_W-1];
  assign full     = (fill_r == CntW'(QUEUE_DEPTH));
  assign empty    = (fill_r == '0);
  assign enq_ok   = (func_r == spq_pkg::FUNC_ENQ) && !bad && !full;
  assign deq_ok   = (func_r == spq_pkg::FUNC_DEQ) && !empty;

  genvar gi;
  for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    logic                          prev_lower;
    logic [spq_pkg::ID_W-1:0]      prev_id, next_id;
    logic [spq_pkg::SLOT_PR_W-1:0] prev_prio, next_prio;

    // A cell is below the insertion point when it is empty or holds a strictly
    // lower priority; the list is sorted, so these cells form a suffix.
    assign lower[gi] = !(fill_r > CntW'(gi)) || (cell_prio_r[gi] < new_prio);

    if (gi == 0) begin : g_head
      assign prev_lower = 1'b0;
      assign prev_id    = id_r;
      assign prev_prio  = new_prio;
    end else begin : g_body
      assign prev_lower = lower[gi-1];
      assign prev_id    = cell_id_r[gi-1];
      assign prev_prio  = cell_prio_r[gi-1];
    end

    if (gi == QUEUE_DEPTH - 1) begin : g_tail
      assign next_id   = cell_id_r[gi];
      assign next_prio = cell_prio_r[gi];
    end else begin : g_mid
      assign next_id   = cell_id_r[gi+1];
      assign next_prio = cell_prio_r[gi+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (enq_ok && lower[gi]) begin
          cell_id_r[gi]   <= prev_lower ? prev_id : id_r;
          cell_prio_r[gi] <= prev_lower ? prev_prio : new_prio;
        end else if (deq_ok) begin
          cell_id_r[gi]   <= next_id;
          cell_prio_r[gi] <= next_prio;
        end
      end
    end
  end

  always_comb begin
    fill_nxt     = fill_r;
    res_id_nxt   = '0;
    res_prio_nxt = '0;
    if (func_r == spq_pkg::FUNC_ENQ) begin
      priority if (bad) begin
        status_nxt = spq_pkg::ST_INVALID;
      end else if (full) begin
        status_nxt = spq_pkg::ST_FULL;
      end else begin
        status_nxt = spq_pkg::ST_ENQUEUED;
        fill_nxt   = fill_r + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else begin
        status_nxt   = spq_pkg::ST_DEQUEUED;
        res_id_nxt   = cell_id_r[0];
        res_prio_nxt = cell_prio_r[0];
        fill_nxt     = fill_r - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.exec) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      id_r     <= in_proc_id;
      prio_r   <= in_prio;
      nempty_r <= in_name_empty;
    end
    if (cmd.exec) begin
      status_r   <= status_nxt;
      res_id_r   <= res_id_nxt;
      res_prio_r <= res_prio_nxt;
    end
  end

  assign res_status = status_r;
  assign res_id     = res_id_r;
  assign res_prio   = res_prio_r;
  assign fill       = fill_r;

endmodule

>>> rtl/stable_priority_queue_core.sv
// Stable priority queue of process entries: top level.
//
// in_req carries one request per handshake: func selects enqueue or dequeue,
// proc_id and prio give the entry, name_empty marks an invalid name. Each
// request gives exactly one result on out_res: status, and for a dequeue the
// identifier and priority of the removed head entry (zero otherwise).
// Entries leave in descending priority; equal priorities leave in arrival order.
// A request is first latched; then every queue cell compares against the new
// priority and shifts in parallel, writing the result register. The next
// request is taken only after the previous one has updated the cells, so
// requests do not overlap. The result is registered and appears on out_res
// once that update has written the result register.
// While a result waits on out_res, one further request is latched; its update
// waits until the result register is taken, and in_req.ready stays low.
// Synchronous reset empties the queue and drops any pending result; the cell
// contents need no clearing since only filled cells are ever read.
module stable_priority_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  spq_in_if.sink          in_req,
  spq_out_if.source       out_res
);

  `include "stable_priority_queue_core_assert.svh"

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  spq_pkg::cmd_t   cmd;
  logic [CntW-1:0] fill;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .cmd       (cmd)
  );

  spq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_func       (in_req.func),
    .in_proc_id    (in_req.proc_id),
    .in_prio       (in_req.prio),
    .in_name_empty (in_req.name_empty),
    .res_status    (out_res.status),
    .res_id        (out_res.out_id),
    .res_prio      (out_res.out_prio),
    .fill          (fill)
  );

  `SPQ_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_req.valid && in_req.ready, !in_req.ready)
  `SPQ_ASSERT_SAME(a_fill_bound, clk, rst_n, 1'b1, fill <= CntW'(QUEUE_DEPTH))
  `SPQ_ASSERT_NEXT(a_exec_gives_result, clk, rst_n, cmd.exec, out_res.valid)
  `SPQ_ASSERT_SAME(a_empty_zero, clk, rst_n, out_res.valid && out_res.status != spq_pkg::ST_DEQUEUED, out_res.out_id == '0 && out_res.out_prio == '0)

endmodule
